@@ rtl/core/bdl_pkg.sv @@
`default_nettype none

package bdl_pkg;

  // Display geometry and blanking span
  localparam int DISPLAY_ROWS = 4;
  localparam int DISPLAY_COLS = 10;
  localparam int BLANK_WIDTH  = 10;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte counter inside one row: spans a blank row or three glyphs
  localparam int CNT_MAX = (BLANK_WIDTH > 3) ? BLANK_WIDTH : 3;
  localparam int CNT_W   = $clog2(CNT_MAX);

  localparam logic [7:0] SPACE_CODE  = 8'd32;
  localparam logic [7:0] CURSOR_CMD  = 8'h80;
  localparam logic [7:0] LINE_ADDR_0 = 8'h00;
  localparam logic [7:0] LINE_ADDR_1 = 8'h40;
  localparam logic [7:0] LINE_ADDR_2 = 8'h0A;
  localparam logic [7:0] LINE_ADDR_3 = 8'h4A;

  // Column offsets of units and tens digits from pos_x
  localparam logic [7:0] COL_OFS_UNITS = 8'd6;
  localparam logic [7:0] COL_OFS_TENS  = 8'd3;

  // Divide by ten for 8-bit values: (n * 205) >> 11
  localparam logic [15:0] DIV10_MUL = 16'd205;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // One decoded draw request
  typedef struct packed {
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [3:0] d0;    // units
    logic [3:0] d1;    // tens
    logic [3:0] d2;    // hundreds
    logic [1:0] ndig;  // 1..3 digits shown
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLANK_CUR,
    S_BLANK_DATA,
    S_DIG_CUR,
    S_DIG_DATA
  } back_state_t;

  // Big-font glyph codes: top row cells 0..2, bottom row cells 3..5
  function automatic logic [7:0] glyph(input logic [3:0] digit, input logic [2:0] idx);
    logic [47:0] cells;
    case (digit)
      4'd1:    cells = {8'd32, 8'd3, 8'd32, 8'd32, 8'd2, 8'd32};
      4'd2:    cells = {8'd6, 8'd6, 8'd2, 8'd3, 8'd7, 8'd7};
      4'd3:    cells = {8'd6, 8'd6, 8'd2, 8'd7, 8'd7, 8'd5};
      4'd4:    cells = {8'd3, 8'd4, 8'd2, 8'd32, 8'd32, 8'd5};
      4'd5:    cells = {8'd0, 8'd6, 8'd6, 8'd7, 8'd7, 8'd5};
      4'd6:    cells = {8'd0, 8'd6, 8'd6, 8'd3, 8'd7, 8'd5};
      4'd7:    cells = {8'd1, 8'd1, 8'd5, 8'd32, 8'd0, 8'd32};
      4'd8:    cells = {8'd0, 8'd6, 8'd2, 8'd3, 8'd7, 8'd5};
      4'd9:    cells = {8'd0, 8'd6, 8'd2, 8'd7, 8'd7, 8'd5};
      default: cells = {8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};
    endcase
    glyph = cells[(5 - int'(idx)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] line_addr(input logic [7:0] row);
    case (row)
      8'd0:    line_addr = LINE_ADDR_0;
      8'd1:    line_addr = LINE_ADDR_1;
      8'd2:    line_addr = LINE_ADDR_2;
      default: line_addr = LINE_ADDR_3;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/big_digit_lcd_command_stream.sv @@
// Big-digit LCD command stream.
// Input channel (in_valid / in_stall): one draw request of pos_x, pos_y and
// number. Output channel (out_valid / out_stall): one controller byte per
// transfer, out_reg_select 0 for a cursor command and 1 for data (glyphs or
// spaces), out_last set on the final byte of a request.
// A front stage splits number into decimal digits and passes the request
// through a two-entry queue to a back sequencer that emits the bytes.
// The back sequencer loads one request at a time and gives each row a
// cursor slot (a skipped cursor is an empty slot) and its data bytes; it
// loads the next request only after the last byte of the current one. Up
// to 46 bytes go out per request. A request passes the front register, a
// queue entry, the sequencer's request register and the output register.
// Up to three requests (front stage plus queue) can wait behind the one
// being drawn; in_stall rises when they are all held.
// While out_stall is high and a byte is valid, the output register holds it
// and the sequencer freezes; the front accepts until it and the queue are full.
// Reset (rst_n low, synchronous) clears the front stage, empties the queue
// and returns the sequencer to idle; no output is valid after reset.
`default_nettype none

module big_digit_lcd_command_stream
  import bdl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_pos_x,
  input  wire logic [7:0] in_pos_y,
  input  wire logic [7:0] in_number,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_reg_select,
  output logic [7:0]      out_lcd_byte,
  output logic            out_last
);

  logic job_valid;
  job_t front_job;
  logic q_full;
  logic q_pop;
  logic q_nonempty;
  job_t q_head;

  bdl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_number (in_number),
    .job_valid (job_valid),
    .job       (front_job),
    .job_full  (q_full)
  );

  bdl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  bdl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_ready      (q_nonempty),
    .job_head       (q_head),
    .job_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reg_select (out_reg_select),
    .out_lcd_byte   (out_lcd_byte),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/core/bdl_front.sv @@
`default_nettype none

module bdl_front
  import bdl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_pos_x,
  input  wire logic [7:0] in_pos_y,
  input  wire logic [7:0] in_number,
  output logic            job_valid,
  output job_t            job,
  input  wire logic       job_full
);

  logic        valid_r;
  job_t        job_r;
  job_t        job_nxt;
  logic [15:0] prod;
  logic [4:0]  q1;
  logic [1:0]  hund;
  logic [7:0]  units_w;
  logic [4:0]  tens_w;
  logic        take;

  // Split the number into decimal digits
  always_comb begin
    prod    = {8'd0, in_number} * DIV10_MUL;
    q1      = prod[15:11];
    units_w = in_number - 8'(q1) * 8'd10;
    if (in_number >= 8'd200) begin
      hund = 2'd2;
    end else if (in_number >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    tens_w = q1 - 5'(hund) * 5'd10;

    job_nxt.pos_x = in_pos_x;
    job_nxt.pos_y = in_pos_y;
    job_nxt.d0    = units_w[3:0];
    job_nxt.d1    = tens_w[3:0];
    job_nxt.d2    = {2'd0, hund};
    if (q1 == 5'd0) begin
      job_nxt.ndig = 2'd1;
    end else if (hund == 2'd0) begin
      job_nxt.ndig = 2'd2;
    end else begin
      job_nxt.ndig = 2'd3;
    end
  end

  // Holding stage in front of the queue
  assign in_stall  = valid_r && job_full;
  assign take      = in_valid && !in_stall;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!job_full) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bdl_queue.sv @@
`default_nettype none

module bdl_queue
  import bdl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      nonempty,
  output job_t      head
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bdl_back.sv @@
`default_nettype none

module bdl_back
  import bdl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_ready,
  input  job_t            job_head,
  output logic            job_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_reg_select,
  output logic [7:0]      out_lcd_byte,
  output logic            out_last
);

  back_state_t      state_r, state_nxt;
  logic             row_r, row_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       dig_r, dig_nxt;
  job_t             job_r;

  logic       out_valid_r;
  logic       out_rs_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       adv;
  logic       emit;
  logic       emit_rs;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic [7:0] cur_row;
  logic [7:0] cur_col;
  logic       cur_ok;
  logic [3:0] cur_digit;
  logic [2:0] gidx;
  logic       dig_final;

  // Output register moves when empty or being taken
  assign adv = !out_valid_r || !out_stall;

  // Cursor position, digit and glyph index of the current row
  always_comb begin
    cur_row = job_r.pos_y + 8'(row_r);
    case (dig_r)
      2'd0:    cur_col = job_r.pos_x + COL_OFS_UNITS;
      2'd1:    cur_col = job_r.pos_x + COL_OFS_TENS;
      default: cur_col = job_r.pos_x;
    endcase
    if (state_r == S_BLANK_CUR) begin
      cur_col = 8'd0;
    end
    cur_ok = (cur_row < 8'(DISPLAY_ROWS)) && (cur_col < 8'(DISPLAY_COLS));
    case (dig_r)
      2'd0:    cur_digit = job_r.d0;
      2'd1:    cur_digit = job_r.d1;
      default: cur_digit = job_r.d2;
    endcase
    gidx      = {1'b0, cnt_r[1:0]} + (row_r ? 3'd3 : 3'd0);
    dig_final = (dig_r == job_r.ndig - 2'd1);
  end

  // Sequencer: blank rows, then each digit row by row
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    job_pop   = 1'b0;
    emit      = 1'b0;
    emit_rs   = RS_DATA;
    emit_byte = SPACE_CODE;
    emit_last = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (job_ready) begin
          job_pop   = 1'b1;
          row_nxt   = 1'b0;
          dig_nxt   = 2'd0;
          state_nxt = S_BLANK_CUR;
        end
      end
      S_BLANK_CUR, S_DIG_CUR: begin
        emit      = cur_ok;
        emit_rs   = RS_CMD;
        emit_byte = CURSOR_CMD | (line_addr(cur_row) + cur_col);
        cnt_nxt   = '0;
        state_nxt = (state_r == S_BLANK_CUR) ? S_BLANK_DATA : S_DIG_DATA;
      end
      S_BLANK_DATA: begin
        emit = 1'b1;
        if (cnt_r == CNT_W'(BLANK_WIDTH - 1)) begin
          row_nxt   = !row_r;
          state_nxt = row_r ? S_DIG_CUR : S_BLANK_CUR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIG_DATA: begin
        emit      = 1'b1;
        emit_byte = glyph(cur_digit, gidx);
        if (cnt_r == CNT_W'(2)) begin
          row_nxt = !row_r;
          if (row_r && dig_final) begin
            emit_last = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            if (row_r) begin
              dig_nxt = dig_r + 2'd1;
            end
            state_nxt = S_DIG_CUR;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (!adv) begin
      state_nxt = state_r;
      row_nxt   = row_r;
      cnt_nxt   = cnt_r;
      dig_nxt   = dig_r;
      job_pop   = 1'b0;
      emit      = 1'b0;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= 1'b0;
      cnt_r   <= '0;
      dig_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
      dig_r   <= dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_head;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rs_r   <= emit_rs;
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_lcd_byte   = out_byte_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_rs_r == RS_DATA))
    else $error("last marked on a command byte");

  a_final_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG_DATA && adv && row_r && dig_final && cnt_r == CNT_W'(2))
      |=> (out_valid_r && out_last_r && state_r == S_IDLE))
    else $error("final glyph did not close the request");

  a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG_CUR || state_r == S_DIG_DATA) |-> (dig_r < job_r.ndig))
    else $error("digit index beyond digit count");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == S_IDLE && job_ready))
    else $error("request popped while busy");
`endif

endmodule

`default_nettype wire
